// ===== rtl/core/bcme_pkg.sv =====
package bcme_pkg;

  // Field widths of the input, result and configuration words.
  localparam int OP_W   = 2;
  localparam int BEAM_W = 2;
  localparam int SLOT_W = 12;
  localparam int RF_W   = 16;
  localparam int SPC_W  = 12;
  localparam int BCNT_W = 12;
  localparam int STAT_W = 2;
  localparam int OFS_W  = 12;
  localparam int SCNT_W = 12;
  localparam int WIN_W  = 12;

  // Train slot position and step widths.
  localparam int POS_W  = 13;
  localparam int STEP_W = 8;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD_BUNCH = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD_TRAIN = 2'd1;
  localparam logic [OP_W-1:0] OP_QUERY     = 2'd2;
  localparam logic [OP_W-1:0] OP_COUNT     = 2'd3;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD_BEAM = 2'd1;
  localparam logic [STAT_W-1:0] ST_RANGE    = 2'd2;

  // Beam numbers accepted on add operations.
  localparam logic [BEAM_W-1:0] BEAM_ONE = 2'd1;
  localparam logic [BEAM_W-1:0] BEAM_TWO = 2'd2;

  // Reciprocal multipliers: x/10 = (x*52429)>>19 for 16-bit x,
  // x/25 = (x*41944)>>20 for 12-bit x.
  localparam int MUL_W = 16;
  localparam logic [MUL_W-1:0] DIV10_MUL = 16'd52429;
  localparam int DIV10_SHIFT = 19;
  localparam logic [MUL_W-1:0] DIV25_MUL = 16'd41944;
  localparam int DIV25_SHIFT = 20;

  // Saturation value of the sensitive slot count.
  localparam logic [SCNT_W-1:0] SCNT_MAX = 12'hFFF;

  // Sweep request from the sequencer.
  typedef struct packed {
    logic              start;
    logic              is_count;
    logic [SLOT_W-1:0] slot;
  } scan_req_t;

  // Sweep answers back to the sequencer.
  typedef struct packed {
    logic              coll;
    logic              sens;
    logic [OFS_W-1:0]  off;
    logic [SCNT_W-1:0] cnt;
  } scan_res_t;

endpackage

// ===== rtl/core/bcme_ram.sv =====
module bcme_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 3564
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/core/bcme_scan.sv =====
module bcme_scan #(
  parameter int ORBIT_SLOTS = 3564
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  bcme_pkg::scan_req_t              req,
  input  logic [bcme_pkg::WIN_W-1:0]       window,
  output logic [$clog2(ORBIT_SLOTS)-1:0]   rd_addr,
  input  logic                             rd_one,
  input  logic                             rd_two,
  output bcme_pkg::scan_res_t              res,
  output logic                             done
);
  import bcme_pkg::*;

  localparam int IDX_W = $clog2(ORBIT_SLOTS);
  localparam int CNT_W = $clog2(ORBIT_SLOTS + 1);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ORBIT_SLOTS - 1);
  localparam logic [CNT_W-1:0] SLOTS_C  = CNT_W'(ORBIT_SLOTS);
  localparam logic [IDX_W:0]   SLOTS_X  = (IDX_W + 1)'(ORBIT_SLOTS);

  // Sweep phases.
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_FIND = 2'd1;
  localparam logic [1:0] PH_EVAL = 2'd2;
  localparam logic [1:0] PH_LAST = 2'd3;

  logic [1:0]        phase_r;
  logic [CNT_W-1:0]  rd_cnt_r;
  logic              dv_r;
  logic              done_r;
  logic [IDX_W-1:0]  didx_r;
  logic              mode_count_r;
  logic [IDX_W-1:0]  qslot_r;
  logic [IDX_W-1:0]  last_r;
  logic              any_r;
  logic              f0_r;
  logic              prev_f_r;
  logic              cur_f_r;
  logic              cur_c_r;
  logic [IDX_W-1:0]  cur_idx_r;
  logic [SCNT_W-1:0] cnt_r;
  logic              q_coll_r;
  logic              q_sens_r;
  logic [IDX_W-1:0]  q_off_r;

  logic             issue;
  logic             d_f;
  logic             d_c;
  logic             eval_en;
  logic             next_f;
  logic             sens;
  logic [IDX_W:0]   diff;
  logic [IDX_W:0]   diff_wrap;
  logic [IDX_W-1:0] off;
  logic             in_win;

  // Read issue: one slot per cycle during both passes.
  assign issue   = ((phase_r == PH_FIND) || (phase_r == PH_EVAL)) && (rd_cnt_r != SLOTS_C);
  assign rd_addr = rd_cnt_r[IDX_W-1:0];
  assign d_f     = rd_one | rd_two;
  assign d_c     = rd_one & rd_two;

  // The slot under evaluation is the one before the arriving word, or the last slot.
  assign eval_en = ((phase_r == PH_EVAL) && dv_r && (didx_r != '0)) || (phase_r == PH_LAST);
  assign next_f  = (phase_r == PH_LAST) ? f0_r : d_f;
  assign sens    = !prev_f_r && !cur_f_r && !next_f;

  // Shared offset unit: cyclic distance back to the previous colliding slot.
  assign diff      = {1'b0, cur_idx_r} - {1'b0, last_r};
  assign diff_wrap = diff + SLOTS_X;
  assign off       = !any_r ? '0 : (diff[IDX_W] ? diff_wrap[IDX_W-1:0] : diff[IDX_W-1:0]);
  assign in_win    = {1'b0, window} > (WIN_W + 1)'(off);

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_IDLE;
      rd_cnt_r <= '0;
      dv_r     <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r <= 1'b0;
      dv_r   <= issue;
      if (issue) begin
        rd_cnt_r <= rd_cnt_r + 1'b1;
      end
      case (phase_r)
        PH_IDLE: begin
          if (req.start) begin
            phase_r  <= PH_FIND;
            rd_cnt_r <= '0;
          end
        end
        PH_FIND: begin
          if (dv_r && (didx_r == LAST_IDX)) begin
            phase_r  <= PH_EVAL;
            rd_cnt_r <= '0;
          end
        end
        PH_EVAL: begin
          if (dv_r && (didx_r == LAST_IDX)) begin
            phase_r <= PH_LAST;
          end
        end
        PH_LAST: begin
          phase_r <= PH_IDLE;
          done_r  <= 1'b1;
        end
        default: begin
          phase_r <= PH_IDLE;
        end
      endcase
    end
  end

  // Sweep datapath.
  always_ff @(posedge clk) begin
    didx_r <= rd_addr;
    if ((phase_r == PH_IDLE) && req.start) begin
      mode_count_r <= req.is_count;
      qslot_r      <= IDX_W'(req.slot);
      any_r        <= 1'b0;
      last_r       <= '0;
      cnt_r        <= '0;
      q_coll_r     <= 1'b0;
      q_sens_r     <= 1'b0;
      q_off_r      <= '0;
    end
    // First pass: highest colliding slot and the fill of both orbit ends.
    if ((phase_r == PH_FIND) && dv_r) begin
      if (d_c) begin
        last_r <= didx_r;
        any_r  <= 1'b1;
      end
      if (didx_r == '0) begin
        f0_r <= d_f;
      end
      if (didx_r == LAST_IDX) begin
        prev_f_r <= d_f;
      end
    end
    // Second pass: slide a three-slot window over the orbit.
    if ((phase_r == PH_EVAL) && dv_r) begin
      if (didx_r != '0) begin
        prev_f_r <= cur_f_r;
      end
      cur_f_r   <= d_f;
      cur_c_r   <= d_c;
      cur_idx_r <= didx_r;
    end
    if (eval_en) begin
      if (cur_c_r) begin
        last_r <= cur_idx_r;
      end
      if (mode_count_r && sens && in_win && (cnt_r != SCNT_MAX)) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (!mode_count_r && (cur_idx_r == qslot_r)) begin
        q_coll_r <= cur_c_r;
        q_sens_r <= sens;
        q_off_r  <= off;
      end
    end
  end

  assign res.coll = q_coll_r;
  assign res.sens = q_sens_r;
  assign res.off  = OFS_W'(q_off_r);
  assign res.cnt  = cnt_r;
  assign done     = done_r;

endmodule

// ===== rtl/core/bunch_crossing_mask_engine.sv =====
// Keeps one fill bitmap per beam over an orbit of ORBIT_SLOTS slots, each in its own
// single-port-read RAM. After reset the block runs a clearing pass over every slot
// that zeroes both bitmaps, and takes no input word until it ends (the window
// register can be written at any time, cfg_ready is always high). Add bunch writes its
// bit as it is accepted and then goes to the response state. Add train uses the shared
// reciprocal multiplier first in S_DIV10 for the first slot, then in S_DIV25 for the
// step, then writes one bitmap bit per bunch, stopping early once the train leaves the
// orbit. For query and count the read ports of both RAMs sweep the orbit one slot per
// cycle twice, once to find the highest colliding slot and the fill at both ends, once to
// evaluate each slot through the shared offset unit. One word is in work at a time;
// the next word may be accepted while the previous result waits in the output register.
module bunch_crossing_mask_engine #(
  parameter int ORBIT_SLOTS = 3564
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bcme_pkg::WIN_W-1:0]    cfg_time_window_bx,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [bcme_pkg::OP_W-1:0]     in_operation,
  input  logic [bcme_pkg::BEAM_W-1:0]   in_beam_number,
  input  logic [bcme_pkg::SLOT_W-1:0]   in_bunch_index,
  input  logic [bcme_pkg::RF_W-1:0]     in_rf_bucket,
  input  logic [bcme_pkg::SPC_W-1:0]    in_bunch_spacing_ns,
  input  logic [bcme_pkg::BCNT_W-1:0]   in_bunch_count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [bcme_pkg::STAT_W-1:0]   out_status,
  output logic                          out_is_colliding,
  output logic                          out_is_sensitive,
  output logic [bcme_pkg::OFS_W-1:0]    out_lumi_offset,
  output logic [bcme_pkg::SCNT_W-1:0]   out_sensitive_count
);
  import bcme_pkg::*;

  localparam int IDX_W = $clog2(ORBIT_SLOTS);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(ORBIT_SLOTS - 1);
  localparam logic [SLOT_W:0]   SLOTS_S  = (SLOT_W + 1)'(ORBIT_SLOTS);
  localparam logic [POS_W-1:0]  SLOTS_P  = POS_W'(ORBIT_SLOTS);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DIV10 = 3'd2;
  localparam logic [2:0] S_DIV25 = 3'd3;
  localparam logic [2:0] S_TRAIN = 3'd4;
  localparam logic [2:0] S_SCAN  = 3'd5;
  localparam logic [2:0] S_RESP  = 3'd6;

  logic [2:0]        state_r;
  logic [IDX_W-1:0]  clr_cnt_r;
  logic [WIN_W-1:0]  window_r;
  logic              out_valid_r;
  logic              sel_two_r;
  logic [RF_W-1:0]   rf_r;
  logic [SPC_W-1:0]  spc_r;
  logic [BCNT_W-1:0] bcnt_r;
  logic [POS_W-1:0]  pos_r;
  logic [STEP_W-1:0] step_r;
  logic [STAT_W-1:0] res_status_r;
  logic              res_coll_r;
  logic              res_sens_r;
  logic [OFS_W-1:0]  res_off_r;
  logic [SCNT_W-1:0] res_cnt_r;
  logic [STAT_W-1:0] out_status_r;
  logic              out_coll_r;
  logic              out_sens_r;
  logic [OFS_W-1:0]  out_off_r;
  logic [SCNT_W-1:0] out_cnt_r;

  logic               accept;
  logic               beam_ok;
  logic               slot_ok;
  logic               in_sel_two;
  logic               train_wr;
  logic               out_load;
  logic [IDX_W-1:0]   wr_addr;
  logic               wr_data;
  logic               we_one;
  logic               we_two;
  logic [MUL_W-1:0]   mul_a;
  logic [MUL_W-1:0]   mul_b;
  logic [2*MUL_W-1:0] mul_p;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_one;
  logic               rd_two;
  scan_req_t          scan_req;
  scan_res_t          scan_res;
  logic               scan_done;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign out_load  = (state_r == S_RESP) && (!out_valid_r || out_ready);

  // Input word checks.
  assign beam_ok    = (in_beam_number == BEAM_ONE) || (in_beam_number == BEAM_TWO);
  assign slot_ok    = {1'b0, in_bunch_index} < SLOTS_S;
  assign in_sel_two = (in_beam_number == BEAM_TWO);
  assign train_wr   = (state_r == S_TRAIN) && (bcnt_r != '0) && (pos_r < SLOTS_P);

  // Bitmap write port: clearing pass, single bunch, or one train bunch.
  always_comb begin
    wr_addr = '0;
    wr_data = 1'b1;
    we_one  = 1'b0;
    we_two  = 1'b0;
    if (state_r == S_CLEAR) begin
      wr_addr = clr_cnt_r;
      wr_data = 1'b0;
      we_one  = 1'b1;
      we_two  = 1'b1;
    end else if (accept && (in_operation == OP_ADD_BUNCH) && beam_ok && slot_ok) begin
      wr_addr = IDX_W'(in_bunch_index);
      we_one  = !in_sel_two;
      we_two  = in_sel_two;
    end else if (train_wr) begin
      wr_addr = IDX_W'(pos_r);
      we_one  = !sel_two_r;
      we_two  = sel_two_r;
    end
  end

  // Shared reciprocal multiplier for the train start slot and step.
  assign mul_a = (state_r == S_DIV10) ? rf_r : MUL_W'(spc_r);
  assign mul_b = (state_r == S_DIV10) ? DIV10_MUL : DIV25_MUL;
  assign mul_p = mul_a * mul_b;

  // Sweep request on a query with a valid slot, or on a count.
  assign scan_req.start    = accept && (((in_operation == OP_QUERY) && slot_ok) ||
                                        (in_operation == OP_COUNT));
  assign scan_req.is_count = (in_operation == OP_COUNT);
  assign scan_req.slot     = in_bunch_index;

  bcme_ram #(
    .WIDTH (1),
    .DEPTH (ORBIT_SLOTS)
  ) u_beam_one (
    .clk     (clk),
    .we      (we_one),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_one)
  );

  bcme_ram #(
    .WIDTH (1),
    .DEPTH (ORBIT_SLOTS)
  ) u_beam_two (
    .clk     (clk),
    .we      (we_two),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_two)
  );

  bcme_scan #(
    .ORBIT_SLOTS (ORBIT_SLOTS)
  ) u_scan (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (scan_req),
    .window  (window_r),
    .rd_addr (rd_addr),
    .rd_one  (rd_one),
    .rd_two  (rd_two),
    .res     (scan_res),
    .done    (scan_done)
  );

  // Sequencer, window register and output valid.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      window_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_time_window_bx;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == LAST_IDX) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (in_operation)
              OP_ADD_TRAIN: state_r <= beam_ok ? S_DIV10 : S_RESP;
              OP_QUERY:     state_r <= slot_ok ? S_SCAN : S_RESP;
              OP_COUNT:     state_r <= S_SCAN;
              default:      state_r <= S_RESP;
            endcase
          end
        end
        S_DIV10: state_r <= S_DIV25;
        S_DIV25: state_r <= S_TRAIN;
        S_TRAIN: begin
          if ((bcnt_r == '0) || (pos_r >= SLOTS_P)) begin
            state_r <= S_RESP;
          end
        end
        S_SCAN: begin
          if (scan_done) begin
            state_r <= S_RESP;
          end
        end
        S_RESP: begin
          if (out_load) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Operation datapath and result words.
  always_ff @(posedge clk) begin
    if (accept) begin
      sel_two_r  <= in_sel_two;
      rf_r       <= in_rf_bucket;
      spc_r      <= in_bunch_spacing_ns;
      bcnt_r     <= in_bunch_count;
      res_coll_r <= 1'b0;
      res_sens_r <= 1'b0;
      res_off_r  <= '0;
      res_cnt_r  <= '0;
      case (in_operation)
        OP_ADD_BUNCH: res_status_r <= !beam_ok ? ST_BAD_BEAM : (!slot_ok ? ST_RANGE : ST_OK);
        OP_ADD_TRAIN: res_status_r <= !beam_ok ? ST_BAD_BEAM : ST_OK;
        OP_QUERY:     res_status_r <= !slot_ok ? ST_RANGE : ST_OK;
        default:      res_status_r <= ST_OK;
      endcase
    end
    if (state_r == S_DIV10) begin
      pos_r <= POS_W'(mul_p >> DIV10_SHIFT) + 1'b1;
    end
    if (state_r == S_DIV25) begin
      step_r <= STEP_W'(mul_p >> DIV25_SHIFT);
    end
    // The train stops at the first bunch past the orbit; all later ones are past it too.
    if ((state_r == S_TRAIN) && (bcnt_r != '0)) begin
      if (pos_r >= SLOTS_P) begin
        res_status_r <= ST_RANGE;
      end else begin
        pos_r  <= pos_r + POS_W'(step_r);
        bcnt_r <= bcnt_r - 1'b1;
      end
    end
    if ((state_r == S_SCAN) && scan_done) begin
      res_coll_r <= scan_res.coll;
      res_sens_r <= scan_res.sens;
      res_off_r  <= scan_res.off;
      res_cnt_r  <= scan_res.cnt;
    end
    if (out_load) begin
      out_status_r <= res_status_r;
      out_coll_r   <= res_coll_r;
      out_sens_r   <= res_sens_r;
      out_off_r    <= res_off_r;
      out_cnt_r    <= res_cnt_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_is_colliding    = out_coll_r;
  assign out_is_sensitive    = out_sens_r;
  assign out_lumi_offset     = out_off_r;
  assign out_sensitive_count = out_cnt_r;

endmodule

// ===== rtl/core/bcme_checker.sv =====
module bcme_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [bcme_pkg::STAT_W-1:0] out_status,
  input logic                        out_is_colliding,
  input logic                        out_is_sensitive,
  input logic [bcme_pkg::OFS_W-1:0]  out_lumi_offset,
  input logic [bcme_pkg::SCNT_W-1:0] out_sensitive_count
);
  import bcme_pkg::*;

  // A stalled result word holds its value.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
      $stable(out_lumi_offset) && $stable(out_sensitive_count))
    else $error("result word changed while stalled");

  // Every accepted word keeps the block busy for at least the next cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted back to back");

  // A failed operation answers with zero fields.
  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ST_OK) |-> !out_is_colliding && !out_is_sensitive &&
      (out_lumi_offset == '0) && (out_sensitive_count == '0))
    else $error("nonzero answer with error status");

  // A colliding slot is filled, so it can never be sensitive.
  a_coll_not_sens: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_is_colliding && out_is_sensitive))
    else $error("slot reported both colliding and sensitive");

endmodule

bind bunch_crossing_mask_engine bcme_checker u_bcme_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .in_valid            (in_valid),
  .in_ready            (in_ready),
  .out_valid           (out_valid),
  .out_ready           (out_ready),
  .out_status          (out_status),
  .out_is_colliding    (out_is_colliding),
  .out_is_sensitive    (out_is_sensitive),
  .out_lumi_offset     (out_lumi_offset),
  .out_sensitive_count (out_sensitive_count)
);
